// File: rtl/core/m4rt_pkg.sv
// Package for the 4x4 fixed-point row transform unit.
// Holds the beat type passed between cells, operation codes and the saturation helper.
// No dependencies.
package m4rt_pkg;

    localparam int COLS  = 4;
    localparam int Q_W   = 32;
    localparam int IDX_W = 2;
    localparam int PROD_W = 2 * Q_W;
    // Four full-width products summed exactly, plus sign headroom.
    localparam int ACC_W = PROD_W + 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ROW  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                              op;
        logic [IDX_W-1:0]                 tag;
        logic [IDX_W-1:0]                 load_row;
        logic [IDX_W-1:0]                 load_col;
        logic [Q_W-1:0]                   load_value;
        logic [COLS-1:0][Q_W-1:0]         left;
        logic [COLS-1:0][ACC_W-1:0]       acc;
    } t_beat;

    localparam logic signed [ACC_W-1:0] SAT_HI = $signed({{(ACC_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO = $signed({{(ACC_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}});

    // Clamp a shifted sum to the signed 32-bit range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[Q_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[Q_W-1:0];
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/m4rt_item_if.sv
// Input channel of the row transform unit: valid/ready handshake and item fields.
// Depends on nothing.
interface m4rt_item_if;
    logic                valid;
    logic                ready;
    logic                operation;
    logic [1:0]          load_row;
    logic [1:0]          load_column;
    logic signed [31:0]  load_value;
    logic [1:0]          row_tag;
    logic signed [31:0]  left_element_0;
    logic signed [31:0]  left_element_1;
    logic signed [31:0]  left_element_2;
    logic signed [31:0]  left_element_3;

    modport source (
        output valid, operation, load_row, load_column, load_value, row_tag,
               left_element_0, left_element_1, left_element_2, left_element_3,
        input  ready
    );
    modport sink (
        input  valid, operation, load_row, load_column, load_value, row_tag,
               left_element_0, left_element_1, left_element_2, left_element_3,
        output ready
    );
endinterface

// File: rtl/core/m4rt_result_if.sv
// Output channel of the row transform unit: valid/ready handshake and product row.
// Depends on nothing.
interface m4rt_result_if;
    logic                valid;
    logic                ready;
    logic [1:0]          result_row;
    logic signed [31:0]  product_0;
    logic signed [31:0]  product_1;
    logic signed [31:0]  product_2;
    logic signed [31:0]  product_3;

    modport source (
        output valid, result_row, product_0, product_1, product_2, product_3,
        input  ready
    );
    modport sink (
        input  valid, result_row, product_0, product_1, product_2, product_3,
        output ready
    );
endinterface

// File: rtl/core/matrix4_row_transform_unit.sv
// Top level of the 4x4 fixed-point row transform unit.
// Uses m4rt_pkg, m4rt_item_if, m4rt_result_if and a chain of m4rt_cell.
//
// The block multiplies left-matrix rows by a stored right matrix in signed
// Q16.16 fixed point. One input channel (i_item) carries two kinds of beat:
// a load beat writes one right-matrix element, a row beat carries one left
// row and produces exactly one result beat on o_result with the product row
// and the copied row tag. Each product is the exact sum of the full-width
// products, shifted right by FRAC_BITS (toward minus infinity) and saturated.
//
// Every beat, loads included, travels down a chain of one cell per matrix
// row. Cell k owns row k of the right matrix, so a load takes effect in order
// with the rows that were accepted before and after it. Each cell has a
// multiply register and an accumulate register. The first multiply register
// fills at the accepting edge; the last accumulate register feeds the
// saturation and output register. One beat is accepted per cycle while the
// receiver does not stall the chain, with one multiplier per column in each
// cell.
//
// After reset the right matrix is the identity and the chain is empty. When
// the receiver stalls, beats keep moving into empty stages behind the output
// register; input ready drops only once every stage is occupied.
module matrix4_row_transform_unit #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    m4rt_item_if.sink     i_item,
    m4rt_result_if.source o_result
);
    import m4rt_pkg::*;

    // Load indexes are two bits wide and only four left elements exist, so
    // rows and columns past the fourth can never be written or contribute.
    localparam int NUSE = (DIM < COLS) ? DIM : COLS;

    t_beat             w_beat  [NUSE+1];
    logic [NUSE:0]     w_valid;
    logic [NUSE:0]     w_ready;

    logic                   r_out_valid;
    logic [IDX_W-1:0]       r_result_row;
    logic signed [Q_W-1:0]  r_product [COLS];
    logic signed [ACC_W-1:0] w_shift  [COLS];
    logic                   w_last_take;

    // Entry beat: sums start at zero.
    always_comb begin
        w_beat[0].op         = t_op'(i_item.operation);
        w_beat[0].tag        = i_item.row_tag;
        w_beat[0].load_row   = i_item.load_row;
        w_beat[0].load_col   = i_item.load_column;
        w_beat[0].load_value = i_item.load_value;
        w_beat[0].left[0]    = i_item.left_element_0;
        w_beat[0].left[1]    = i_item.left_element_1;
        w_beat[0].left[2]    = i_item.left_element_2;
        w_beat[0].left[3]    = i_item.left_element_3;
        w_beat[0].acc        = '0;
    end

    assign w_valid[0]   = i_item.valid;
    assign i_item.ready = w_ready[0];

    for (genvar k = 0; k < NUSE; k++) begin : g_cell
        m4rt_cell #(
            .CELL_IDX  (k),
            .NCOL      (NUSE),
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_beat  (w_beat[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_beat  (w_beat[k+1])
        );
    end

    // Output stage: load beats are dropped here, row beats are saturated and
    // held until the receiver takes them.
    assign w_ready[NUSE] = !r_out_valid || o_result.ready;
    assign w_last_take   = w_valid[NUSE] && w_ready[NUSE];

    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            w_shift[c] = $signed(w_beat[NUSE].acc[c]) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_last_take && w_beat[NUSE].op == OP_ROW) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last_take && w_beat[NUSE].op == OP_ROW) begin
            r_result_row <= w_beat[NUSE].tag;
            for (int c = 0; c < COLS; c++) begin
                r_product[c] <= sat_q(w_shift[c]);
            end
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.result_row = r_result_row;
    assign o_result.product_0  = r_product[0];
    assign o_result.product_1  = r_product[1];
    assign o_result.product_2  = r_product[2];
    assign o_result.product_3  = r_product[3];

    // The output register comes up empty out of reset.
    a_out_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");

    // With the output register empty the whole chain drains, so input is ready.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.valid |-> i_item.ready)
        else $error("input stalled while the output register is empty");

    // A result never appears without a beat having left the chain.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_valid[NUSE]))
        else $error("result beat without a beat from the cell chain");

endmodule

// File: rtl/core/m4rt_cell.sv
// One cell of the transform chain: holds one row of the right matrix, multiplies
// it by its left element and adds into the running column sums. Uses m4rt_pkg.
module m4rt_cell #(
    parameter int CELL_IDX  = 0,
    parameter int NCOL      = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  m4rt_pkg::t_beat i_beat,
    output logic            o_valid,
    input  logic            i_ready,
    output m4rt_pkg::t_beat o_beat
);
    import m4rt_pkg::*;

    localparam logic [IDX_W-1:0] MY_ROW = IDX_W'(CELL_IDX);

    logic signed [Q_W-1:0]    r_row [NCOL];
    logic                     r_a_valid;
    t_beat                    r_a_beat;
    logic signed [PROD_W-1:0] r_prod [NCOL];
    logic                     r_b_valid;
    t_beat                    r_b_beat;
    t_beat                    n_b_beat;

    logic w_a_ready;
    logic w_b_ready;
    logic w_take;
    logic w_move;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign w_take    = i_valid && w_a_ready;
    assign w_move    = r_a_valid && w_b_ready;
    assign o_ready   = w_a_ready;
    assign o_valid   = r_b_valid;
    assign o_beat    = r_b_beat;

    // Right-matrix row. A load beat writes here when it passes this cell, so
    // it is ordered exactly against the row beats around it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCOL; c++) begin
                r_row[c] <= (c == CELL_IDX) ? Q_W'(1) << FRAC_BITS : '0;
            end
        end else if (w_take && i_beat.op == OP_LOAD && i_beat.load_row == MY_ROW) begin
            for (int c = 0; c < NCOL; c++) begin
                if (i_beat.load_col == IDX_W'(c)) begin
                    r_row[c] <= $signed(i_beat.load_value);
                end
            end
        end
    end

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_take) begin
            r_a_valid <= 1'b1;
        end else if (w_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a_beat <= i_beat;
            for (int c = 0; c < NCOL; c++) begin
                r_prod[c] <= $signed(i_beat.left[CELL_IDX]) * r_row[c];
            end
        end
    end

    // Accumulate stage.
    always_comb begin
        n_b_beat = r_a_beat;
        for (int c = 0; c < NCOL; c++) begin
            n_b_beat.acc[c] = $signed(r_a_beat.acc[c])
                + $signed({{(ACC_W-PROD_W){r_prod[c][PROD_W-1]}}, r_prod[c]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_move) begin
            r_b_valid <= 1'b1;
        end else if (i_ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_b_beat <= n_b_beat;
        end
    end

endmodule
